### rtl/core/rls_pkg.sv
// shared constants and types for the running log statistics block
`default_nettype none
package rls_pkg;
  localparam int MaxDims    = 64;
  localparam int DimBits    = 6;
  localparam int CntBits    = 20;
  localparam int CountW     = CntBits + 1;
  localparam int SumW       = 52;
  localparam int DivW       = SumW + 1;
  localparam int LnSteps    = 28;
  localparam int EntryW     = 32 + 32 + SumW + SumW;
  localparam logic [29:0] Ln2Q30 = 30'd744261118;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_IDX = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_ONE     = 2'd3;

  typedef struct packed {
    logic [31:0]            min_v;
    logic [31:0]            max_v;
    logic signed [SumW-1:0] sum;
    logic [SumW-1:0]        sumsq;
  } entry_t;
endpackage
`default_nettype wire

### rtl/core/rls_ram.sv
// generic single-port ram with registered read
`default_nettype none
module rls_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

### rtl/core/running_log_statistics.sv
// top level: per-dimension min, max, log mean and log variance
// add item: read, 28-step squaring loop, ln2 product, square, write; an ignored item skips these
// query item: result after two 53-step restoring divisions (one with one sample, none with
//   a bad index or no samples); next item is taken in the cycle after the result
// a waiting result holds only the output step of the next query, not the input
// reset: clearing pass over all 64 entries of the store, one entry a cycle, no item taken
`default_nettype none
module running_log_statistics (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [6:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // operation, dimension, sample_value, pad
  input  wire logic [39:0] s_axis_tdata_i,
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // min_value, max_value, log_mean, log_variance, sample_count, pad
  output logic [151:0]     m_axis_tdata_o,
  // status
  output logic [1:0]       m_axis_tuser_o
);
  import rls_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_LN, S_LNMUL, S_SQ, S_WRITE,
    S_QLOAD, S_DIV, S_MEAN, S_MSQ, S_VAR, S_OUT
  } state_e;

  state_e state_q;
  logic [DimBits-1:0] addr_q;
  logic op_q, valid_q;
  logic [31:0] v_q;
  logic [6:0] dims_q;
  logic [CountW-1:0] cnt_q;
  logic [5:0] step_q;
  logic [31:0] m_q;
  logic [27:0] frac_q;
  logic [4:0] e_q;
  logic [28:0] prod_q;
  logic neg_q;
  logic [31:0] l_q;
  logic [33:0] sq_q;
  // divider
  logic [DivW-1:0] dq_q;
  logic [CountW-1:0] dr_q;
  logic div_sel_q;
  logic signed [31:0] mean_q, var_q;
  logic [39:0] msq_q;
  logic [1:0] st_q;
  entry_t ent_q, rd, wd, upd;
  logic we;

  logic [31:0] vc;
  logic [4:0] msb;
  logic in_valid;
  logic out_free;
  logic [63:0] mm_w;
  logic [33:0] lfix;
  logic [32:0] lmag;
  logic [63:0] prod_w;
  logic [57:0] sqp_w;
  logic [SumW:0] sum_w;
  logic [SumW:0] sq_w;
  logic [DivW-1:0] sext_w, smag_w;
  logic [CountW-1:0] half_w;
  logic [CountW:0] t_w, diff_w;
  logic [31:0] am_w;
  logic [63:0] msq_w;
  logic [DivW:0] vdiff_w;

  rls_ram #(.Width(EntryW), .Depth(MaxDims)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr_q), .wdata_i(wd), .rdata_o(rd)
  );

  assign cfg_ready_o = (state_q == S_IDLE);
  assign s_axis_tready_o = (state_q == S_IDLE) && !cfg_valid_i;
  assign we = (state_q == S_CLEAR) || (state_q == S_WRITE);
  assign out_free = !m_axis_tvalid_o || m_axis_tready_i;

  // clamped sample and its highest set bit
  always_comb begin
    vc = (s_axis_tdata_i[38:7] == '0) ? 32'd1 : s_axis_tdata_i[38:7];
    msb = '0;
    for (int i = 0; i < 32; i++) if (vc[i]) msb = 5'(i);
    in_valid = {1'b0, s_axis_tdata_i[6:1]} < dims_q;
  end

  always_comb begin
    // log datapath
    mm_w   = {32'd0, m_q} * {32'd0, m_q};
    lfix   = {6'({1'b0, e_q} - 6'd16), frac_q};
    lmag   = lfix[33] ? 33'(~lfix + 34'd1) : lfix[32:0];
    prod_w = {31'd0, lmag} * {34'd0, Ln2Q30} + 64'h2_0000_0000;
    sqp_w  = {29'd0, prod_q} * {29'd0, prod_q} + 58'h80_0000;
    // entry update with saturating sums
    sum_w  = {ent_q.sum[SumW-1], ent_q.sum} + {{(SumW+1-32){l_q[31]}}, l_q};
    sq_w   = {1'b0, ent_q.sumsq} + (SumW+1)'(sq_q);
    upd    = ent_q;
    if (v_q < ent_q.min_v) upd.min_v = v_q;
    if (v_q > ent_q.max_v) upd.max_v = v_q;
    if (sum_w[SumW] != sum_w[SumW-1]) begin
      upd.sum = sum_w[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      upd.sum = sum_w[SumW-1:0];
    end
    upd.sumsq = sq_w[SumW] ? '1 : sq_w[SumW-1:0];
    // query datapath
    sext_w  = {rd.sum[SumW-1], rd.sum};
    smag_w  = sext_w[DivW-1] ? (DivW'(0) - sext_w) : sext_w;
    half_w  = cnt_q >> 1;
    t_w     = {dr_q, dq_q[DivW-1]};
    diff_w  = t_w - {1'b0, cnt_q};
    am_w    = mean_q[31] ? (32'd0 - mean_q) : mean_q;
    msq_w   = {32'd0, am_w} * {32'd0, am_w} + 64'h80_0000;
    vdiff_w = {1'b0, dq_q} - (DivW+1)'(msq_q);
  end

  always_comb begin
    if (state_q == S_CLEAR) begin
      wd = '{min_v: '1, max_v: '0, sum: '0, sumsq: '0};
    end else begin
      wd = upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      addr_q <= '0;
      op_q <= 1'b0;
      valid_q <= 1'b0;
      v_q <= '0;
      dims_q <= 7'd64;
      cnt_q <= '0;
      step_q <= '0;
      m_q <= '0;
      frac_q <= '0;
      e_q <= '0;
      prod_q <= '0;
      neg_q <= 1'b0;
      l_q <= '0;
      sq_q <= '0;
      dq_q <= '0;
      dr_q <= '0;
      div_sel_q <= 1'b0;
      mean_q <= '0;
      var_q <= '0;
      msq_q <= '0;
      st_q <= ST_OK;
      ent_q <= '0;
      m_axis_tvalid_o <= 1'b0;
      m_axis_tdata_o <= '0;
      m_axis_tuser_o <= '0;
    end else begin
      if (state_q == S_OUT && out_free) m_axis_tvalid_o <= 1'b1;
      else if (m_axis_tvalid_o && m_axis_tready_i) m_axis_tvalid_o <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) dims_q <= cfg_data_i;
      unique case (state_q)
        S_CLEAR: begin
          addr_q <= addr_q + DimBits'(1);
          if (addr_q == DimBits'(MaxDims - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid_i && s_axis_tready_o) begin
            op_q <= s_axis_tdata_i[0];
            addr_q <= s_axis_tdata_i[6:1];
            valid_q <= in_valid;
            v_q <= vc;
            e_q <= msb;
            m_q <= vc << (5'd31 - msb);
            frac_q <= '0;
            step_q <= '0;
            if (s_axis_tdata_i[0] == OP_QUERY) begin
              state_q <= S_READ;
            end else if (!cnt_q[CntBits]) begin
              // a bad index still counts the end of a sample
              if (s_axis_tlast_i) cnt_q <= cnt_q + CountW'(1);
              if (in_valid) state_q <= S_READ;
            end
          end
        end
        S_READ: state_q <= (op_q == OP_ADD) ? S_LN : S_QLOAD;
        S_LN: begin
          if (step_q == 6'd0) ent_q <= rd;
          if (mm_w[63]) begin
            m_q <= mm_w[63:32]; frac_q <= {frac_q[26:0], 1'b1};
          end else begin
            m_q <= mm_w[62:31]; frac_q <= {frac_q[26:0], 1'b0};
          end
          step_q <= step_q + 6'd1;
          if (step_q == 6'(LnSteps - 1)) state_q <= S_LNMUL;
        end
        S_LNMUL: begin
          prod_q <= prod_w[62:34];
          neg_q <= lfix[33];
          state_q <= S_SQ;
        end
        S_SQ: begin
          l_q <= neg_q ? (32'd0 - 32'(prod_q)) : 32'(prod_q);
          sq_q <= sqp_w[57:24];
          state_q <= S_WRITE;
        end
        S_WRITE: state_q <= S_IDLE;
        S_QLOAD: begin
          ent_q <= rd;
          neg_q <= rd.sum[SumW-1];
          dq_q <= smag_w + DivW'(half_w);
          dr_q <= '0;
          step_q <= '0;
          div_sel_q <= 1'b0;
          mean_q <= '0;
          var_q <= '0;
          if (!valid_q) st_q <= ST_BAD_IDX;
          else if (cnt_q == '0) st_q <= ST_EMPTY;
          else if (cnt_q == CountW'(1)) st_q <= ST_ONE;
          else st_q <= ST_OK;
          if (!valid_q || cnt_q == '0) state_q <= S_OUT;
          else state_q <= S_DIV;
        end
        S_DIV: begin
          // restoring division by the sample count, one quotient bit a cycle
          if (!diff_w[CountW]) begin
            dr_q <= diff_w[CountW-1:0]; dq_q <= {dq_q[DivW-2:0], 1'b1};
          end else begin
            dr_q <= t_w[CountW-1:0]; dq_q <= {dq_q[DivW-2:0], 1'b0};
          end
          step_q <= step_q + 6'd1;
          if (step_q == 6'(DivW - 1)) state_q <= div_sel_q ? S_VAR : S_MEAN;
        end
        S_MEAN: begin
          if (!neg_q) begin
            mean_q <= (|dq_q[DivW-1:31]) ? 32'h7FFF_FFFF : dq_q[31:0];
          end else begin
            mean_q <= (|dq_q[DivW-1:32] || (dq_q[31] && |dq_q[30:0])) ? 32'h8000_0000
                                                                       : 32'd0 - dq_q[31:0];
          end
          if (cnt_q == CountW'(1)) state_q <= S_OUT;
          else state_q <= S_MSQ;
        end
        S_MSQ: begin
          msq_q <= msq_w[63:24];
          dq_q <= {1'b0, ent_q.sumsq} + DivW'(half_w);
          dr_q <= '0;
          step_q <= '0;
          div_sel_q <= 1'b1;
          state_q <= S_DIV;
        end
        S_VAR: begin
          if (&vdiff_w[DivW:31] || ~|vdiff_w[DivW:31]) var_q <= vdiff_w[31:0];
          else if (vdiff_w[DivW]) var_q <= 32'h8000_0000;
          else var_q <= 32'h7FFF_FFFF;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tdata_o <= {3'd0, cnt_q, var_q, mean_q,
                               (st_q == ST_BAD_IDX) ? 32'd0 : ent_q.max_v,
                               (st_q == ST_BAD_IDX) ? 32'd0 : ent_q.min_v};
            m_axis_tuser_o <= st_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
